/* hdl/rsl_pkg.sv */
// Shared types and constants for the radial spotlight luminance block.
// Used by rsl_sqrt_stage and radial_spotlight_luminance; depends on nothing.
package rsl_pkg;

  localparam int CENTER_BITS = 14;   // width of the centre registers
  localparam int CFG_IDX_W   = 1;    // configuration index width

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  localparam int NEAR_LIM = 160;     // distance where attenuation saturates
  localparam int SQ_W     = 16;      // |dx|^2 + |dy|^2 with |dx|,|dy| < 160
  localparam int AXIS_W   = 8;       // |dx| or |dy| below NEAR_LIM

  localparam logic [SQ_W-1:0] FAR_SQ = 16'd25600;
  localparam logic [15:0]     ATT_MAX = 16'd52428;   // floor(0.8 * 65536)

  // floor(r * 32 / 25) == (r * ATT_RECIP) >> RECIP_SHIFT for r < 58254
  localparam int                ATT_RECIP_W = 21;
  localparam logic [20:0]       ATT_RECIP   = 21'd1342178;
  localparam int                RECIP_SHIFT = 20;

  // Square root of s * 65536, two result bits per pipeline stage
  localparam int RAD_W          = 32;
  localparam int ROOT_W         = 16;
  localparam int REM_W          = 19;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

endpackage

/* hdl/rsl_sqrt_stage.sv */
// One registered stage of the digit-by-digit square root.
// Retires SQRT_PER_STAGE root bits; uses rsl_pkg types and constants.
module rsl_sqrt_stage #(
  parameter int SIDE_W = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rsl_pkg::sqrt_t      sq_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output rsl_pkg::sqrt_t      sq_o,
  output logic [SIDE_W-1:0]   side_o
);

  rsl_pkg::sqrt_t                 cur;
  rsl_pkg::sqrt_t                 sq_d;
  rsl_pkg::sqrt_t                 sq_q;
  logic [rsl_pkg::REM_W-1:0]      acc;
  logic [rsl_pkg::REM_W-1:0]      trial;
  logic                           valid_q;
  logic [SIDE_W-1:0]              side_q;

  // Bring down the next bit pair, try (4*root + 1), keep or drop it.
  always_comb begin
    cur   = sq_i;
    acc   = '0;
    trial = '0;
    for (int k = 0; k < rsl_pkg::SQRT_PER_STAGE; k++) begin
      acc   = {cur.rem[rsl_pkg::REM_W-3:0], cur.rad[rsl_pkg::RAD_W-1 -: 2]};
      trial = rsl_pkg::REM_W'({cur.root, 2'b01});
      if (acc >= trial) begin
        cur.rem  = acc - trial;
        cur.root = {cur.root[rsl_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        cur.rem  = acc;
        cur.root = {cur.root[rsl_pkg::ROOT_W-2:0], 1'b0};
      end
      cur.rad = {cur.rad[rsl_pkg::RAD_W-3:0], 2'b00};
    end
    sq_d = cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign side_o  = side_q;

endmodule

/* hdl/radial_spotlight_luminance.sv */
// Radial spotlight luminance: dims each pixel by 0.5% per pixel of distance, capped at 80%.
// 12 register stages, among them the 8-stage square root (2 root bits per stage).
// Throughput: one pixel per cycle while the output is not stalled.
// A stall freezes the whole pipeline; bubbles travel as cleared valid bits.
// Reset clears all valid bits and both centre registers; payload registers are not reset.
// Depends on rsl_pkg and rsl_sqrt_stage.
module radial_spotlight_luminance #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel transaction in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [COORD_BITS-1:0]               pixel_x_i,
  input  logic [COORD_BITS-1:0]               pixel_y_i,
  input  logic [LUM_BITS-1:0]                 lum_in_i,
  // result transaction out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [LUM_BITS-1:0]                 lum_out_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rsl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rsl_pkg::CENTER_BITS-1:0]     cfg_data_i
);

  // Signed difference wide enough for any centre minus any pixel coordinate.
  localparam int DW = ((rsl_pkg::CENTER_BITS > COORD_BITS + 1) ?
                       rsl_pkg::CENTER_BITS : COORD_BITS + 1) + 1;
  localparam int SIDE_W  = LUM_BITS + 1;
  localparam int PROD_W  = rsl_pkg::ROOT_W + rsl_pkg::ATT_RECIP_W;
  localparam int GAIN_W  = 17;
  localparam int OUT_P_W = LUM_BITS + GAIN_W;

  // ---------------------------------------------------------------------------
  // Configuration: centre registers, unchecked: user must write only while the block is idle
  // ---------------------------------------------------------------------------
  logic signed [rsl_pkg::CENTER_BITS-1:0] center_x_q;
  logic signed [rsl_pkg::CENTER_BITS-1:0] center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsl_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
        rsl_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the pipeline moves unless the output holds a stalled result
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Stage 1: per-axis distance, absolute value, near test
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]          dx;
  logic signed [DW-1:0]          dy;
  logic [DW-1:0]                 adx;
  logic [DW-1:0]                 ady;
  logic                          near;
  logic                          v1_q;
  logic [rsl_pkg::AXIS_W-1:0]    adx_q;
  logic [rsl_pkg::AXIS_W-1:0]    ady_q;
  logic                          near1_q;
  logic [LUM_BITS-1:0]           lum1_q;

  assign dx   = DW'(center_x_q) - DW'($signed({1'b0, pixel_x_i}));
  assign dy   = DW'(center_y_q) - DW'($signed({1'b0, pixel_y_i}));
  assign adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
  // Either axis at 160 or beyond puts s at 25600 or more: saturated.
  assign near = (adx < DW'(rsl_pkg::NEAR_LIM)) && (ady < DW'(rsl_pkg::NEAR_LIM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q   <= adx[rsl_pkg::AXIS_W-1:0];
      ady_q   <= ady[rsl_pkg::AXIS_W-1:0];
      near1_q <= near;
      lum1_q  <= lum_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squared distance of near pixels
  // ---------------------------------------------------------------------------
  logic [rsl_pkg::SQ_W-1:0] sq_sum;
  logic                     v2_q;
  logic [rsl_pkg::SQ_W-1:0] sq2_q;
  logic                     near2_q;
  logic [LUM_BITS-1:0]      lum2_q;

  assign sq_sum = rsl_pkg::SQ_W'(adx_q) * rsl_pkg::SQ_W'(adx_q) +
                  rsl_pkg::SQ_W'(ady_q) * rsl_pkg::SQ_W'(ady_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq2_q   <= sq_sum;
      near2_q <= near1_q;
      lum2_q  <= lum1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3..10: r = isqrt(s * 65536); far pixels feed a zero radicand
  // ---------------------------------------------------------------------------
  logic                  far2;
  logic                  sqrt_valid [0:rsl_pkg::SQRT_STAGES];
  rsl_pkg::sqrt_t        sqrt_st    [0:rsl_pkg::SQRT_STAGES];
  logic [SIDE_W-1:0]     sqrt_side  [0:rsl_pkg::SQRT_STAGES];

  assign far2          = !near2_q || (sq2_q >= rsl_pkg::FAR_SQ);
  assign sqrt_valid[0] = v2_q;
  assign sqrt_st[0].rem  = '0;
  assign sqrt_st[0].root = '0;
  assign sqrt_st[0].rad  = far2 ? '0 : {sq2_q, 16'd0};
  assign sqrt_side[0]    = {far2, lum2_q};

  for (genvar g = 0; g < rsl_pkg::SQRT_STAGES; g++) begin : g_sqrt
    rsl_sqrt_stage #(
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sqrt_valid[g]),
      .sq_i    (sqrt_st[g]),
      .side_i  (sqrt_side[g]),
      .valid_o (sqrt_valid[g+1]),
      .sq_o    (sqrt_st[g+1]),
      .side_o  (sqrt_side[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 11: attenuation A = floor(r * 32 / 25), saturated for far pixels
  // ---------------------------------------------------------------------------
  logic [rsl_pkg::ROOT_W-1:0] root;
  logic                       far_s;
  logic [LUM_BITS-1:0]        lum_s;
  logic [PROD_W-1:0]          att_prod;
  logic                       att_valid_q;
  logic [15:0]                att_q;
  logic [LUM_BITS-1:0]        att_lum_q;

  assign root     = sqrt_st[rsl_pkg::SQRT_STAGES].root;
  assign far_s    = sqrt_side[rsl_pkg::SQRT_STAGES][LUM_BITS];
  assign lum_s    = sqrt_side[rsl_pkg::SQRT_STAGES][LUM_BITS-1:0];
  assign att_prod = PROD_W'(root) * PROD_W'(rsl_pkg::ATT_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_valid_q <= 1'b0;
    end else if (en) begin
      att_valid_q <= sqrt_valid[rsl_pkg::SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      att_q     <= far_s ? rsl_pkg::ATT_MAX : att_prod[rsl_pkg::RECIP_SHIFT +: 16];
      att_lum_q <= lum_s;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 12: lum_out = floor(lum * (65536 - A) / 65536); output register
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]   gain;
  logic [OUT_P_W-1:0]  out_prod;
  logic [LUM_BITS-1:0] lum_out_q;

  assign gain     = GAIN_W'(17'h10000) - GAIN_W'(att_q);
  assign out_prod = OUT_P_W'(att_lum_q) * OUT_P_W'(gain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= att_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lum_out_q <= out_prod[16 +: LUM_BITS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign lum_out_o   = lum_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted pixel must land in the first stage.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted pixel did not enter stage 1");

  // Dimming never brightens a pixel.
  a_no_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && att_valid_q) |=> (lum_out_q <= $past(att_lum_q)))
    else $error("output luminance exceeds input luminance");

  // A near pixel has s < 25600, so its root stays below 160 * 256.
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sqrt_valid[rsl_pkg::SQRT_STAGES] && !far_s) |-> (root < 16'd40960))
    else $error("square root out of range for a near pixel");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for radial_spotlight_luminance: streams pixel transactions
// under random idling and back-pressure, and checks every dimmed luminance in order.
// Depends on rsl_pkg and the radial_spotlight_luminance RTL.
module testbench;

  localparam int PIX_W           = 12;
  localparam int LUM_W           = 16;
  localparam int SAT_DIST_SQ     = 25600;    // distance 160 and beyond saturates
  localparam int SAT_ATTEN       = 52428;    // 80% dimming in Q0.16
  localparam int DRAIN_CYCLES    = 20;       // comfortably above the 12-stage pipeline
  localparam int HOLD_OFF_CYCLES = 400;      // long receiver stall to fill the pipeline
  localparam int CYCLE_LIMIT     = 1000000;

  // Expected-result tracker: holds its own copy of the centre registers, predicts
  // the dimmed luminance of each accepted pixel and compares results in order.
  class spotlight_scoreboard;
    logic signed [rsl_pkg::CENTER_BITS-1:0] center_x;
    logic signed [rsl_pkg::CENTER_BITS-1:0] center_y;
    logic [LUM_W-1:0]                       dimmed_lum_q[$];
    int                                     errors;

    function new();
      center_x = '0;
      center_y = '0;
      errors   = 0;
    endfunction

    function void set_center(logic [rsl_pkg::CFG_IDX_W-1:0] idx,
                             logic [rsl_pkg::CENTER_BITS-1:0] data);
      case (idx)
        rsl_pkg::REG_CENTER_X: center_x = data;
        rsl_pkg::REG_CENTER_Y: center_y = data;
        default: ;
      endcase
    endfunction

    // Squared distance, Q.8 root by digit recurrence, linear attenuation, scale.
    function logic [LUM_W-1:0] dimmed_lum(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                          logic [LUM_W-1:0] lum);
      longint dx, dy, dist_sq, rad, root, probe, atten;
      dx      = longint'(center_x) - longint'(px);
      dy      = longint'(center_y) - longint'(py);
      dist_sq = dx * dx + dy * dy;
      if (dist_sq >= SAT_DIST_SQ) begin
        atten = SAT_ATTEN;
      end else begin
        rad   = dist_sq << 16;
        root  = 0;
        probe = longint'(1) << 30;
        while (probe != 0) begin
          if (rad >= root + probe) begin
            rad  = rad - (root + probe);
            root = (root >> 1) + probe;
          end else begin
            root = root >> 1;
          end
          probe = probe >> 2;
        end
        atten = (root * 32) / 25;
      end
      return LUM_W'((longint'(lum) * (65536 - atten)) >> 16);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                             logic [LUM_W-1:0] lum);
      dimmed_lum_q.push_back(dimmed_lum(px, py, lum));
    endfunction

    function void check_lum(logic [LUM_W-1:0] got);
      logic [LUM_W-1:0] want;
      if (dimmed_lum_q.size() == 0) begin
        $display("%0t: unexpected lum_out transaction, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = dimmed_lum_q.pop_front();
        if (want !== got) begin
          $display("%0t: lum_out mismatch, expected %h, got %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return dimmed_lum_q.size();
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [PIX_W-1:0]                pixel_x_i   = '0;
  logic [PIX_W-1:0]                pixel_y_i   = '0;
  logic [LUM_W-1:0]                lum_in_i    = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [LUM_W-1:0]                lum_out_o;
  logic                            cfg_we_i    = 1'b0;
  logic [rsl_pkg::CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [rsl_pkg::CENTER_BITS-1:0] cfg_data_i  = '0;

  spotlight_scoreboard sb;

  // Idling knobs, set per phase: percent chance of starting a stall or a gap.
  int rx_stall_pct  = 0;
  int tx_gap_pct    = 0;
  bit hold_off_req  = 1'b0;
  int cycle_count   = 0;

  radial_spotlight_luminance #(
    .COORD_BITS(PIX_W),
    .LUM_BITS  (LUM_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .lum_in_i   (lum_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .lum_out_o  (lum_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: fail the run if it is still going when cycle_count reaches CYCLE_LIMIT.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("radial_spotlight_luminance test failed");
    $finish;
  end

  // Most idle stretches are short; one in ten is long.
  function automatic int idle_len();
    if ($urandom_range(9, 0) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic int input_gap();
    if ($urandom_range(99, 0) < tx_gap_pct) begin
      return idle_len();
    end
    return 0;
  endfunction

  // Result side: drive stall at the falling edge. A hold-off request from the
  // stimulus is turned into a long stall counted here, cycle by cycle.
  initial begin : result_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(99, 0) < rx_stall_pct) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // Check every result transaction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_lum(lum_out_o);
    end
  end

  // Offer one pixel transaction after an optional gap; hold the payload until
  // accepted, then note it. Valid stays high into the next transaction when
  // there is no gap.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                            input logic [LUM_W-1:0] lum);
    int gap;
    gap = input_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    lum_in_i   <= lum;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_pixel(px, py, lum);
  endtask

  // Write one centre register; only called while the pipeline is empty.
  task automatic write_center(input logic [rsl_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= rsl_pkg::CENTER_BITS'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_center(idx, rsl_pkg::CENTER_BITS'(value));
  endtask

  // Drop valid, wait for all expected results, then let the pipeline empty.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Pick a coordinate within reach of the centre, clipped to the image.
  function automatic logic [PIX_W-1:0] coord_near(input int center, input int reach);
    int v;
    v = center - reach + int'($urandom_range(2 * reach, 0));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return PIX_W'(v);
  endfunction

  function automatic logic [LUM_W-1:0] random_lum();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return LUM_W'($urandom);
  endfunction

  // Mostly pixels within 170 of the centre per axis, around the unsaturated disc,
  // some close to the centre and some anywhere in the coordinate space.
  task automatic random_pixels(input int cx, input int cy, input int count, input bit hold);
    int               kind;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    for (int n = 0; n < count; n++) begin
      if (hold && n == count / 4) hold_off_req = 1'b1;
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
        px = coord_near(cx, 170);
        py = coord_near(cy, 170);
      end else if (kind < 80) begin
        px = coord_near(cx, 12);
        py = coord_near(cy, 12);
      end else begin
        px = PIX_W'($urandom);
        py = PIX_W'($urandom);
      end
      send_pixel(px, py, random_lum());
    end
  endtask

  task automatic run_phase(input int cx, input int cy, input int count,
                           input int rx_pct, input int tx_pct, input bit hold);
    write_center(rsl_pkg::REG_CENTER_X, cx);
    write_center(rsl_pkg::REG_CENTER_Y, cy);
    rx_stall_pct = rx_pct;
    tx_gap_pct   = tx_pct;
    random_pixels(cx, cy, count, hold);
    settle();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pixels against the reset centre at the origin: on the centre,
    // luminance extremes, the saturation boundary and far corners.
    rx_stall_pct = 20;
    tx_gap_pct   = 20;
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'h0000);
    send_pixel(12'd0, 12'd0, 16'h0001);
    send_pixel(12'd1, 12'd0, 16'hFFFF);
    send_pixel(12'd1, 12'd1, 16'hFFFF);
    send_pixel(12'd0, 12'd1, 16'h8000);
    send_pixel(12'd159, 12'd0, 16'hFFFF);
    send_pixel(12'd160, 12'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd159, 16'hFFFF);
    send_pixel(12'd113, 12'd113, 16'hFFFF);
    send_pixel(12'd113, 12'd114, 16'hFFFF);
    send_pixel(12'd100, 12'd50, 16'hAAAA);
    send_pixel(12'd50, 12'd100, 16'h5555);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd4095, 12'd0, 16'h1234);
    send_pixel(12'd0, 12'd4095, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, 16'h0000);
    send_pixel(12'd2, 12'd3, 16'h0001);
    send_pixel(12'd12, 12'd5, 16'hFFFF);
    send_pixel(12'd7, 12'd24, 16'hFFFE);
    random_pixels(0, 0, 250, 1'b0);
    settle();

    // Sweep centre settings: mid image with no idling, both register extremes,
    // centres off the image edge, a long receiver hold-off and heavy idling.
    run_phase(2048, 2048, 200, 0, 0, 1'b0);
    run_phase(-8192, -8192, 60, 25, 25, 1'b0);
    run_phase(8191, 8191, 60, 25, 25, 1'b0);
    run_phase(-100, 4000, 200, 15, 15, 1'b0);
    run_phase(4095, 0, 200, 10, 0, 1'b1);
    run_phase(300, 3900, 200, 50, 50, 1'b0);
    run_phase(int'($urandom_range(4095, 0)), int'($urandom_range(4095, 0)), 200, 20, 20, 1'b0);
    run_phase(-4096, 8191, 60, 20, 20, 1'b0);
    run_phase(1234, 77, 200, 5, 5, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("radial_spotlight_luminance test passed");
    end else begin
      $display("radial_spotlight_luminance test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rsl_pkg.sv
hdl/rsl_sqrt_stage.sv
hdl/radial_spotlight_luminance.sv
dv/testbench.sv
